// ----- rtl/core/affw_pkg.sv -----
`default_nettype none

package affw_pkg;

  // Default geometry and sample format
  localparam int WIDTH_DEF       = 64;
  localparam int HEIGHT_DEF      = 64;
  localparam int CHANNELS_DEF    = 3;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed field widths
  localparam int POS_W  = 6;
  localparam int SMP_W  = 16;
  localparam int COEF_W = 24;
  localparam int IDX_W  = 3;
  localparam int FRAC_W = 16;
  localparam int MAX_CH = 3;

  // Datapath widths
  localparam int PROD_W = COEF_W + POS_W + 1;  // coefficient times coordinate
  localparam int SX_W   = 32;                  // mapped source point, Q16
  localparam int CW     = 18;                  // signed neighbour coordinate
  localparam int WT_W   = 2 * FRAC_W + 1;      // Q32 weight, up to 1.0

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [CW-1:0]     coord_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } op_t;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_XX   = 3'd0,
    REG_GAIN_XY   = 3'd1,
    REG_OFFSET_X  = 3'd2,
    REG_GAIN_YX   = 3'd3,
    REG_GAIN_YY   = 3'd4,
    REG_OFFSET_Y  = 3'd5,
    REG_EDGE_MODE = 3'd6
  } reg_idx_t;

  typedef struct packed {
    op_t                     opcode;
    logic [POS_W-1:0]        pos_x;
    logic [POS_W-1:0]        pos_y;
    logic signed [SMP_W-1:0] sample_a;
    logic signed [SMP_W-1:0] sample_b;
    logic signed [SMP_W-1:0] sample_c;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0]        out_x;
    logic [POS_W-1:0]        out_y;
    logic signed [SMP_W-1:0] value_a;
    logic signed [SMP_W-1:0] value_b;
    logic signed [SMP_W-1:0] value_c;
  } out_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [COEF_W-1:0] value;
  } cfg_word_t;

  typedef struct packed {
    coef_t gain_xx;
    coef_t gain_xy;
    coef_t offset_x;
    coef_t gain_yx;
    coef_t gain_yy;
    coef_t offset_y;
    logic  edge_mode;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    gain_xx:   coef_t'(65536),
    gain_xy:   coef_t'(0),
    offset_x:  coef_t'(0),
    gain_yx:   coef_t'(0),
    gain_yy:   coef_t'(65536),
    offset_y:  coef_t'(0),
    edge_mode: 1'b0
  };

  // Compute item on its way from address generation to the blend
  typedef struct packed {
    logic              valid;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [FRAC_W-1:0] fx;
    logic [FRAC_W-1:0] fy;
  } ctl_t;

  typedef struct packed {
    coord_t lo;
    coord_t hi;
  } coord_pair_t;

  localparam coord_t ZERO_C = coord_t'(0);
  localparam coord_t ONE_C  = coord_t'(1);
  localparam coord_t TWO_C  = coord_t'(2);

  // Edge handling for one neighbour pair, then clamp whatever is left over
  function automatic coord_pair_t fix_coord(coord_t a1_in, coord_t a2_in, coord_t size,
                                            logic refl);
    coord_t      a1;
    coord_t      b;
    coord_t      lim;
    coord_pair_t r;
    a1  = a1_in;
    b   = a2_in;
    lim = size - ONE_C;
    if (!refl) begin
      if (a1 < ZERO_C) begin
        a1 = ZERO_C;
        if (b < ZERO_C) b = ZERO_C;
      end
      if (b >= size) begin
        b = lim;
        if (a1 >= size) a1 = lim;
      end
    end else begin
      if (a1 < ZERO_C) begin
        a1 = -a1;
        if (b < ZERO_C) b = -b;
      end
      if (b >= size) begin
        b = (size <<< 1) - TWO_C - b;
        if (a1 >= size) a1 = (size <<< 1) - TWO_C - a1;
      end
    end
    if (a1 < ZERO_C) a1 = ZERO_C;
    if (a1 > lim)    a1 = lim;
    if (b < ZERO_C)  b  = ZERO_C;
    if (b > lim)     b  = lim;
    r.lo = a1;
    r.hi = b;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/affw_if.sv -----
`default_nettype none

interface affw_in_if;
  logic               valid;
  logic               ready;
  affw_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface affw_out_if;
  logic                valid;
  logic                ready;
  affw_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface affw_cfg_if;
  logic                valid;
  logic                ready;
  affw_pkg::cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/affw_ram.sv -----
`default_nettype none

module affw_ram #(
  parameter int  DW    = 48,
  parameter int  DEPTH = 4096,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  output logic [DW-1:0] rdata0,
  output logic [DW-1:0] rdata1
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rdata0_r;
  logic [DW-1:0] rdata1_r;

  // Write one word, read two, read data registered and held when not enabled
  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    if (re) begin
      rdata0_r <= mem_r[raddr0];
      rdata1_r <= mem_r[raddr1];
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

`default_nettype wire

// ----- rtl/core/affw_geom.sv -----
`default_nettype none

module affw_geom #(
  parameter int  WIDTH    = affw_pkg::WIDTH_DEF,
  parameter int  HEIGHT   = affw_pkg::HEIGHT_DEF,
  parameter int  CHANNELS = affw_pkg::CHANNELS_DEF,
  localparam int XW       = $clog2(WIDTH),
  localparam int YW       = $clog2(HEIGHT),
  localparam int AW       = $clog2(WIDTH * HEIGHT),
  localparam int DW       = CHANNELS * affw_pkg::SMP_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  affw_pkg::in_word_t in_word,
  input  affw_pkg::cfg_t     cfg,
  output affw_pkg::ctl_t     ctl,
  output logic [AW-1:0]      rd_addr [4],
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output logic [DW-1:0]      wr_data
);

  localparam int PROD_W = affw_pkg::PROD_W;
  localparam int SX_W   = affw_pkg::SX_W;
  localparam int FRAC_W = affw_pkg::FRAC_W;
  localparam int SMP_W  = affw_pkg::SMP_W;

  logic v1_r, v2_r, v3_r, v4_r;
  affw_pkg::in_word_t w1_r, w2_r, w3_r, w4_r;

  logic signed [PROD_W-1:0] p_xx_r, p_xy_r, p_yx_r, p_yy_r;
  logic signed [SX_W-1:0]   sx_r, sy_r;
  logic [XW-1:0]            x1_r, x2_r;
  logic [YW-1:0]            y1_r, y2_r;
  logic [FRAC_W-1:0]        fx4_r, fy4_r;

  affw_pkg::ctl_t ctl_r;
  logic [AW-1:0]  addr_r [4];
  logic           wr_en_r;
  logic [AW-1:0]  wr_addr_r;
  logic [DW-1:0]  wr_data_r;

  logic signed [affw_pkg::POS_W:0] px_s, py_s;
  affw_pkg::coord_t      x1_c, y1_c;
  affw_pkg::coord_pair_t xp, yp;
  logic [SMP_W-1:0]      smp [affw_pkg::MAX_CH];
  logic [DW-1:0]         wr_data_nxt;
  logic                  in_image;

  function automatic logic [AW-1:0] pix_addr(logic [YW-1:0] y, logic [XW-1:0] x);
    return AW'(y) * AW'(WIDTH) + AW'(x);
  endfunction

  // Advance the valid bits with the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Carry the input word along
  always_ff @(posedge clk) begin
    if (en) begin
      w1_r <= in_word;
      w2_r <= w1_r;
      w3_r <= w2_r;
      w4_r <= w3_r;
    end
  end

  assign px_s = $signed({1'b0, w1_r.pos_x});
  assign py_s = $signed({1'b0, w1_r.pos_y});

  // Coefficient products
  always_ff @(posedge clk) begin
    if (en) begin
      p_xx_r <= cfg.gain_xx * px_s;
      p_xy_r <= cfg.gain_xy * py_s;
      p_yx_r <= cfg.gain_yx * px_s;
      p_yy_r <= cfg.gain_yy * py_s;
    end
  end

  // Sum into the source point
  always_ff @(posedge clk) begin
    if (en) begin
      sx_r <= SX_W'(p_xx_r) + SX_W'(p_xy_r) + SX_W'(cfg.offset_x);
      sy_r <= SX_W'(p_yx_r) + SX_W'(p_yy_r) + SX_W'(cfg.offset_y);
    end
  end

  // Floor, split off the fraction and fix the neighbours at the edges
  always_comb begin
    x1_c = affw_pkg::coord_t'($signed(sx_r[SX_W-1:FRAC_W]));
    y1_c = affw_pkg::coord_t'($signed(sy_r[SX_W-1:FRAC_W]));
    xp   = affw_pkg::fix_coord(x1_c, x1_c + affw_pkg::ONE_C,
                               affw_pkg::coord_t'(WIDTH), cfg.edge_mode);
    yp   = affw_pkg::fix_coord(y1_c, y1_c + affw_pkg::ONE_C,
                               affw_pkg::coord_t'(HEIGHT), cfg.edge_mode);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r  <= xp.lo[XW-1:0];
      x2_r  <= xp.hi[XW-1:0];
      y1_r  <= yp.lo[YW-1:0];
      y2_r  <= yp.hi[YW-1:0];
      fx4_r <= sx_r[FRAC_W-1:0];
      fy4_r <= sy_r[FRAC_W-1:0];
    end
  end

  // Pack the stored channels of a load
  always_comb begin
    smp[0] = w4_r.sample_a;
    smp[1] = w4_r.sample_b;
    smp[2] = w4_r.sample_c;
    wr_data_nxt = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      wr_data_nxt[ch*SMP_W +: SMP_W] = smp[ch];
    end
  end

  assign in_image = (int'(w4_r.pos_x) < WIDTH) && (int'(w4_r.pos_y) < HEIGHT);

  // Control of the memory stage, addresses of the four neighbours and of a load
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
      wr_en_r     <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= v4_r && (w4_r.opcode == affw_pkg::OP_COMPUTE);
      wr_en_r     <= v4_r && (w4_r.opcode == affw_pkg::OP_LOAD) && in_image;
    end
    if (en) begin
      ctl_r.pos_x <= w4_r.pos_x;
      ctl_r.pos_y <= w4_r.pos_y;
      ctl_r.fx    <= fx4_r;
      ctl_r.fy    <= fy4_r;
      addr_r[0]   <= pix_addr(y1_r, x1_r);
      addr_r[1]   <= pix_addr(y2_r, x1_r);
      addr_r[2]   <= pix_addr(y1_r, x2_r);
      addr_r[3]   <= pix_addr(y2_r, x2_r);
      wr_addr_r   <= pix_addr(YW'(w4_r.pos_y), XW'(w4_r.pos_x));
      wr_data_r   <= wr_data_nxt;
    end
  end

  assign ctl     = ctl_r;
  assign rd_addr = addr_r;
  assign wr_en   = wr_en_r && en;
  assign wr_addr = wr_addr_r;
  assign wr_data = wr_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/affw_blend.sv -----
`default_nettype none

module affw_blend #(
  parameter int  CHANNELS    = affw_pkg::CHANNELS_DEF,
  parameter int  SAMPLE_BITS = affw_pkg::SAMPLE_BITS_DEF,
  localparam int DW          = CHANNELS * affw_pkg::SMP_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  affw_pkg::ctl_t      ctl,
  input  logic [DW-1:0]       rd_data [4],
  output logic                out_valid,
  output affw_pkg::out_word_t out_word
);

  localparam int WT_W   = affw_pkg::WT_W;
  localparam int SMP_W  = affw_pkg::SMP_W;
  localparam int FRAC_W = affw_pkg::FRAC_W;
  localparam int PW     = WT_W + 1 + SMP_W;
  localparam int ACC_W  = PW + 2;
  localparam int SHIFT  = 2 * FRAC_W;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'd1 << (SHIFT - 1));
  localparam logic signed [ACC_W-1:0] MAXV = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] MINV = ~MAXV;

  affw_pkg::ctl_t ctl6_r, ctl7_r, ctl8_r;
  logic [WT_W-1:0] w6_r [4];
  logic [FRAC_W:0] gx0, gx1, gy0, gy1;
  logic [affw_pkg::MAX_CH-1:0][SMP_W-1:0] val;

  logic                out_valid_r;
  affw_pkg::out_word_t out_word_r;

  // Advance the item control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl6_r.valid <= 1'b0;
      ctl7_r.valid <= 1'b0;
      ctl8_r.valid <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (en) begin
      ctl6_r.valid <= ctl.valid;
      ctl7_r.valid <= ctl6_r.valid;
      ctl8_r.valid <= ctl7_r.valid;
      out_valid_r  <= ctl8_r.valid;
    end
    if (en) begin
      ctl6_r.pos_x <= ctl.pos_x;
      ctl6_r.pos_y <= ctl.pos_y;
      ctl6_r.fx    <= ctl.fx;
      ctl6_r.fy    <= ctl.fy;
      ctl7_r.pos_x <= ctl6_r.pos_x;
      ctl7_r.pos_y <= ctl6_r.pos_y;
      ctl7_r.fx    <= ctl6_r.fx;
      ctl7_r.fy    <= ctl6_r.fy;
      ctl8_r.pos_x <= ctl7_r.pos_x;
      ctl8_r.pos_y <= ctl7_r.pos_y;
      ctl8_r.fx    <= ctl7_r.fx;
      ctl8_r.fy    <= ctl7_r.fy;
    end
  end

  // Weights, in step with the memory read
  assign gx1 = {1'b0, ctl.fx};
  assign gy1 = {1'b0, ctl.fy};
  assign gx0 = {1'b1, {FRAC_W{1'b0}}} - gx1;
  assign gy0 = {1'b1, {FRAC_W{1'b0}}} - gy1;

  always_ff @(posedge clk) begin
    if (en) begin
      w6_r[0] <= WT_W'(gx0) * WT_W'(gy0);
      w6_r[1] <= WT_W'(gx0) * WT_W'(gy1);
      w6_r[2] <= WT_W'(gx1) * WT_W'(gy0);
      w6_r[3] <= WT_W'(gx1) * WT_W'(gy1);
    end
  end

  // Per channel: weight products, sum, round and saturate
  for (genvar ch = 0; ch < affw_pkg::MAX_CH; ch++) begin : g_ch
    if (ch < CHANNELS) begin : g_on
      logic signed [PW-1:0]    prod_r [4];
      logic signed [ACC_W-1:0] acc_r;
      logic signed [ACC_W-1:0] rnd;
      logic signed [ACC_W-1:0] q;
      logic [SMP_W-1:0]        sat;

      always_ff @(posedge clk) begin
        if (en) begin
          for (int n = 0; n < 4; n++) begin
            prod_r[n] <= $signed({1'b0, w6_r[n]}) * $signed(rd_data[n][ch*SMP_W +: SMP_W]);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          acc_r <= ACC_W'(prod_r[0]) + ACC_W'(prod_r[1]) + ACC_W'(prod_r[2])
                 + ACC_W'(prod_r[3]);
        end
      end

      always_comb begin
        rnd = acc_r + HALF;
        q   = rnd >>> SHIFT;
        if (q > MAXV) begin
          sat = MAXV[SMP_W-1:0];
        end else if (q < MINV) begin
          sat = MINV[SMP_W-1:0];
        end else begin
          sat = q[SMP_W-1:0];
        end
      end

      assign val[ch] = sat;
    end else begin : g_off
      assign val[ch] = '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r.out_x   <= ctl8_r.pos_x;
      out_word_r.out_y   <= ctl8_r.pos_y;
      out_word_r.value_a <= val[0];
      out_word_r.value_b <= val[1];
      out_word_r.value_c <= val[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// ----- rtl/core/affine_warp_bilinear.sv -----
// Affine image warp with bilinear interpolation.
// in_chan: one word per item. A load word writes one pixel (all channels) into
// the source store; a load outside the image is dropped and gives no result.
// A compute word names a destination pixel and gives exactly one result word
// on out_chan, carrying the same position and the interpolated channels.
// cfg_chan: register index and data; always ready. Registers are to be written
// only while the block is idle; the block does not enforce it. Registers take
// their reset values on reset. Throughput: one word per cycle unless stalled.
// The four neighbours are read together from two copies of the source store,
// each with two read ports. Stages: input, products, sums, floor and edge fix,
// addresses, memory read with weights, weight products, sum, output register.
// Reset (rst_n low at a clock edge) empties the pipeline and clears out_valid;
// the source store keeps no reset value and needs no clearing pass, so words
// are taken from the first cycle after reset. Pixels must be loaded before a
// compute word reads them.
// Stall: the whole pipeline holds while a result waits in the output register
// and the receiver is not ready; in_chan.ready drops in the same cycle.
`default_nettype none

module affine_warp_bilinear #(
  parameter int  WIDTH       = affw_pkg::WIDTH_DEF,
  parameter int  HEIGHT      = affw_pkg::HEIGHT_DEF,
  parameter int  CHANNELS    = affw_pkg::CHANNELS_DEF,
  parameter int  SAMPLE_BITS = affw_pkg::SAMPLE_BITS_DEF,
  localparam int AW          = $clog2(WIDTH * HEIGHT),
  localparam int DW          = CHANNELS * affw_pkg::SMP_W
) (
  input  logic       clk,
  input  logic       rst_n,
  affw_in_if.sink    in_chan,
  affw_out_if.source out_chan,
  affw_cfg_if.sink   cfg_chan
);

  affw_pkg::cfg_t cfg_r;
  affw_pkg::ctl_t ctl;
  logic           en;
  logic           out_valid;
  logic [AW-1:0]  rd_addr [4];
  logic [DW-1:0]  rd_data [4];
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic [DW-1:0]  wr_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= affw_pkg::CFG_RST;
    end else if (cfg_chan.valid) begin
      unique case (affw_pkg::reg_idx_t'(cfg_chan.data.index))
        affw_pkg::REG_GAIN_XX:   cfg_r.gain_xx   <= $signed(cfg_chan.data.value);
        affw_pkg::REG_GAIN_XY:   cfg_r.gain_xy   <= $signed(cfg_chan.data.value);
        affw_pkg::REG_OFFSET_X:  cfg_r.offset_x  <= $signed(cfg_chan.data.value);
        affw_pkg::REG_GAIN_YX:   cfg_r.gain_yx   <= $signed(cfg_chan.data.value);
        affw_pkg::REG_GAIN_YY:   cfg_r.gain_yy   <= $signed(cfg_chan.data.value);
        affw_pkg::REG_OFFSET_Y:  cfg_r.offset_y  <= $signed(cfg_chan.data.value);
        affw_pkg::REG_EDGE_MODE: cfg_r.edge_mode <= cfg_chan.data.value[0];
        default: ;
      endcase
    end
  end

  assign cfg_chan.ready = 1'b1;

  // Advance everything unless a result waits unread
  assign en            = !out_valid || out_chan.ready;
  assign in_chan.ready = en;

  affw_geom #(
    .WIDTH    (WIDTH),
    .HEIGHT   (HEIGHT),
    .CHANNELS (CHANNELS)
  ) u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_chan.valid),
    .in_word  (in_chan.data),
    .cfg      (cfg_r),
    .ctl      (ctl),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  // Left column neighbours
  affw_ram #(
    .DW    (DW),
    .DEPTH (WIDTH * HEIGHT)
  ) u_ram_lo (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (wr_addr),
    .wdata  (wr_data),
    .re     (en),
    .raddr0 (rd_addr[0]),
    .raddr1 (rd_addr[1]),
    .rdata0 (rd_data[0]),
    .rdata1 (rd_data[1])
  );

  // Right column neighbours
  affw_ram #(
    .DW    (DW),
    .DEPTH (WIDTH * HEIGHT)
  ) u_ram_hi (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (wr_addr),
    .wdata  (wr_data),
    .re     (en),
    .raddr0 (rd_addr[2]),
    .raddr1 (rd_addr[3]),
    .rdata0 (rd_data[2]),
    .rdata1 (rd_data[3])
  );

  affw_blend #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .ctl       (ctl),
    .rd_data   (rd_data),
    .out_valid (out_valid),
    .out_word  (out_chan.data)
  );

  assign out_chan.valid = out_valid;

endmodule

`default_nettype wire

// ----- rtl/core/affw_chk.sv -----
`default_nettype none

module affw_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input affw_pkg::out_word_t out_data
);

  // A stalled result word stays and holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

  // Reset empties the output
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // Input is taken exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> (in_ready == (!out_valid || out_ready)))
    else $error("input ready does not follow output back-pressure");

  // No input taken while the result is stuck
  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !(in_valid && in_ready))
    else $error("input word taken while the pipeline is stalled");

endmodule

bind affine_warp_bilinear affw_chk u_affw_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_data  (out_chan.data)
);

`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

module tb;

  localparam int IMG_W      = 64;
  localparam int IMG_H      = 64;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_LEN   = 400;
  localparam int SMP_W      = affw_pkg::SMP_W;
  localparam int COEF_W     = affw_pkg::COEF_W;
  localparam int POS_W      = affw_pkg::POS_W;

  // Warp predictor and store of pending pixel results
  class warp_scoreboard;
    logic signed [SMP_W-1:0] pix_store [IMG_W*IMG_H][3];
    longint    coef [6];
    bit        reflect;
    affw_pkg::out_word_t pending [$];
    int        errors;

    function new();
      coef[0] = 65536; coef[1] = 0; coef[2] = 0;
      coef[3] = 0;     coef[4] = 65536; coef[5] = 0;
      reflect = 1'b0;
      errors  = 0;
    endfunction

    function void set_reg(affw_pkg::reg_idx_t idx, logic [COEF_W-1:0] v);
      if (idx == affw_pkg::REG_EDGE_MODE) reflect = v[0];
      else coef[idx] = longint'(signed'(v));
    endfunction

    // Apply edge handling to one neighbour pair, then clamp the leftovers
    function void edge_fix(inout longint a1, inout longint b, input longint size);
      if (!reflect) begin
        if (a1 < 0) begin a1 = 0; if (b < 0) b = 0; end
        if (b >= size) begin b = size - 1; if (a1 >= size) a1 = size - 1; end
      end else begin
        if (a1 < 0) begin a1 = -a1; if (b < 0) b = -b; end
        if (b >= size) begin
          b = 2 * size - 2 - b;
          if (a1 >= size) a1 = 2 * size - 2 - a1;
        end
      end
      if (a1 < 0) a1 = 0;
      if (a1 > size - 1) a1 = size - 1;
      if (b < 0) b = 0;
      if (b > size - 1) b = size - 1;
    endfunction

    // Map a destination pixel to its four neighbours and fractions
    function void map_point(input int x, input int y, output longint x1, output longint x2,
                            output longint y1, output longint y2, output longint fx,
                            output longint fy);
      longint sx, sy;
      sx = coef[0] * x + coef[1] * y + coef[2];
      sy = coef[3] * x + coef[4] * y + coef[5];
      x1 = sx >>> 16;
      y1 = sy >>> 16;
      fx = sx - (x1 <<< 16);
      fy = sy - (y1 <<< 16);
      x2 = x1 + 1;
      y2 = y1 + 1;
      edge_fix(x1, x2, longint'(IMG_W));
      edge_fix(y1, y2, longint'(IMG_H));
    endfunction

    function void note_input(affw_pkg::in_word_t w);
      longint    x1, x2, y1, y2, fx, fy, acc, v;
      longint    w11, w12, w21, w22;
      int        a11, a12, a21, a22;
      affw_pkg::out_word_t r;
      logic [SMP_W-1:0] vals [3];
      if (w.opcode == affw_pkg::OP_LOAD) begin
        pix_store[w.pos_y * IMG_W + w.pos_x][0] = w.sample_a;
        pix_store[w.pos_y * IMG_W + w.pos_x][1] = w.sample_b;
        pix_store[w.pos_y * IMG_W + w.pos_x][2] = w.sample_c;
        return;
      end
      map_point(int'(w.pos_x), int'(w.pos_y), x1, x2, y1, y2, fx, fy);
      w11 = (65536 - fx) * (65536 - fy);
      w12 = (65536 - fx) * fy;
      w21 = fx * (65536 - fy);
      w22 = fx * fy;
      a11 = int'(y1 * IMG_W + x1);
      a12 = int'(y2 * IMG_W + x1);
      a21 = int'(y1 * IMG_W + x2);
      a22 = int'(y2 * IMG_W + x2);
      for (int ch = 0; ch < 3; ch++) begin
        acc = w11 * longint'(pix_store[a11][ch]) + w12 * longint'(pix_store[a12][ch])
            + w21 * longint'(pix_store[a21][ch]) + w22 * longint'(pix_store[a22][ch]);
        v = (acc + 64'sd2147483648) >>> 32;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        vals[ch] = v[SMP_W-1:0];
      end
      r.out_x   = w.pos_x;
      r.out_y   = w.pos_y;
      r.value_a = vals[0];
      r.value_b = vals[1];
      r.value_c = vals[2];
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(affw_pkg::out_word_t got);
      affw_pkg::out_word_t exp_w;
      if (pending.size() == 0) begin
        $error("result word with nothing pending: x=%0d y=%0d", got.out_x, got.out_y);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.out_x !== exp_w.out_x) begin
        $error("out_x expected %0d actual %0d", exp_w.out_x, got.out_x); errors++;
      end
      if (got.out_y !== exp_w.out_y) begin
        $error("out_y expected %0d actual %0d", exp_w.out_y, got.out_y); errors++;
      end
      if (got.value_a !== exp_w.value_a) begin
        $error("value_a expected %0d actual %0d", exp_w.value_a, got.value_a); errors++;
      end
      if (got.value_b !== exp_w.value_b) begin
        $error("value_b expected %0d actual %0d", exp_w.value_b, got.value_b); errors++;
      end
      if (got.value_c !== exp_w.value_c) begin
        $error("value_c expected %0d actual %0d", exp_w.value_c, got.value_c); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  affw_in_if  in_if ();
  affw_out_if out_if ();
  affw_cfg_if cfg_if ();

  affine_warp_bilinear dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  warp_scoreboard sb = new();
  bit     loaded [IMG_W*IMG_H];
  int     burst_left;
  int     idle_cycles;
  int     ready_cyc;
  bit     hold_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Note accepted words on both channels
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) sb.note_input(in_if.data);
    if (rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  // Drive the receiver: rotate stall patterns, honour a long hold-off
  always @(posedge clk) begin
    ready_cyc <= ready_cyc + 1;
    if (hold_req) out_if.ready <= 1'b0;
    else case ((ready_cyc / 97) % 3)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= ($urandom_range(1, 0) != 0);
      default: out_if.ready <= ($urandom_range(7, 0) != 0);
    endcase
  end

  // Hold the receiver off for a fixed stretch once asked
  initial begin
    wait (hold_req);
    repeat (HOLD_LEN) @(posedge clk);
    hold_req = 1'b0;
  end

  // Watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("affine_warp_bilinear verification failed");
      $finish;
    end
  end

  task automatic send_word(affw_pkg::in_word_t w);
    if (burst_left <= 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? 60 : int'($urandom_range(30, 1));
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    burst_left--;
  endtask

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(5, 0))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      default: return SMP_W'($urandom());
    endcase
  endfunction

  task automatic load_pixel(int x, int y);
    affw_pkg::in_word_t w;
    w.opcode   = affw_pkg::OP_LOAD;
    w.pos_x    = POS_W'(x);
    w.pos_y    = POS_W'(y);
    w.sample_a = pick_sample();
    w.sample_b = pick_sample();
    w.sample_c = pick_sample();
    loaded[y * IMG_W + x] = 1'b1;
    send_word(w);
  endtask

  // Load any missing neighbour first, then issue the compute word
  task automatic compute_pixel(int x, int y);
    longint   x1, x2, y1, y2, fx, fy;
    affw_pkg::in_word_t w;
    sb.map_point(x, y, x1, x2, y1, y2, fx, fy);
    if (!loaded[y1 * IMG_W + x1]) load_pixel(int'(x1), int'(y1));
    if (!loaded[y2 * IMG_W + x1]) load_pixel(int'(x1), int'(y2));
    if (!loaded[y1 * IMG_W + x2]) load_pixel(int'(x2), int'(y1));
    if (!loaded[y2 * IMG_W + x2]) load_pixel(int'(x2), int'(y2));
    w.opcode   = affw_pkg::OP_COMPUTE;
    w.pos_x    = POS_W'(x);
    w.pos_y    = POS_W'(y);
    w.sample_a = SMP_W'($urandom());
    w.sample_b = SMP_W'($urandom());
    w.sample_c = SMP_W'($urandom());
    send_word(w);
  endtask

  // Drain the pipeline so that registers may be written
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(affw_pkg::reg_idx_t idx, logic [COEF_W-1:0] v);
    cfg_if.valid       <= 1'b1;
    cfg_if.data.index  <= idx;
    cfg_if.data.value  <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic write_all(logic [COEF_W-1:0] xx, logic [COEF_W-1:0] xy,
                           logic [COEF_W-1:0] ox, logic [COEF_W-1:0] yx,
                           logic [COEF_W-1:0] yy, logic [COEF_W-1:0] oy, logic em);
    write_reg(affw_pkg::REG_GAIN_XX, xx);
    write_reg(affw_pkg::REG_GAIN_XY, xy);
    write_reg(affw_pkg::REG_OFFSET_X, ox);
    write_reg(affw_pkg::REG_GAIN_YX, yx);
    write_reg(affw_pkg::REG_GAIN_YY, yy);
    write_reg(affw_pkg::REG_OFFSET_Y, oy);
    write_reg(affw_pkg::REG_EDGE_MODE, {23'd0, em});
  endtask

  function automatic logic [COEF_W-1:0] moderate_gain();
    int g;
    g = int'($urandom_range(131072, 32768));
    return COEF_W'(($urandom_range(1, 0) != 0) ? -g : g);
  endfunction

  function automatic logic [COEF_W-1:0] small_shear();
    return COEF_W'(int'($urandom_range(40000, 0)) - 20000);
  endfunction

  function automatic logic [COEF_W-1:0] pixel_offset();
    return COEF_W'(int'($urandom_range(24 * 65536, 0)) - 8 * 65536);
  endfunction

  // Random words: mostly computes, some noise loads
  task automatic random_run(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(4, 0) == 0)
        load_pixel(int'($urandom_range(63, 0)), int'($urandom_range(63, 0)));
      else
        compute_pixel(int'($urandom_range(63, 0)), int'($urandom_range(63, 0)));
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    burst_left   = 0;
    idle_cycles  = 0;
    ready_cyc    = 0;
    hold_req     = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corners, extreme samples, identity map at the borders
    load_pixel(0, 0);
    load_pixel(63, 63);
    load_pixel(63, 0);
    load_pixel(0, 63);
    compute_pixel(0, 0);
    compute_pixel(63, 63);
    compute_pixel(63, 0);
    compute_pixel(0, 63);
    wait_idle();

    // Directed: half-pixel shift, clamp then reflect at both edges
    write_all(24'd65536, 24'd0, 24'd32768, 24'd0, 24'd65536, -24'sd32768, 1'b0);
    compute_pixel(0, 0);
    compute_pixel(63, 63);
    compute_pixel(31, 17);
    wait_idle();
    write_all(-24'sd65536, 24'd0, 24'd32768, 24'd0, 24'd65536, 24'd4128768, 1'b1);
    compute_pixel(0, 0);
    compute_pixel(63, 63);
    compute_pixel(5, 40);
    wait_idle();

    // Random, moderate maps in both edge modes
    write_all(moderate_gain(), small_shear(), pixel_offset(), small_shear(),
              moderate_gain(), pixel_offset(), 1'b0);
    random_run(40);
    wait_idle();
    write_all(moderate_gain(), small_shear(), pixel_offset(), small_shear(),
              moderate_gain(), pixel_offset(), 1'b1);
    random_run(40);
    wait_idle();

    // Extremes of every register
    write_all(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
    random_run(20);
    wait_idle();
    write_all(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'h800000, 1'b1);
    random_run(20);
    wait_idle();

    // Full-range random registers
    write_all(COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()),
              COEF_W'($urandom()), COEF_W'($urandom()), COEF_W'($urandom()),
              1'($urandom_range(1, 0)));
    random_run(30);
    wait_idle();

    // Long receiver hold-off while the sender keeps offering
    write_all(moderate_gain(), small_shear(), pixel_offset(), small_shear(),
              moderate_gain(), pixel_offset(), 1'b1);
    hold_req = 1'b1;
    random_run(60);
    wait_idle();

    write_all(moderate_gain(), small_shear(), pixel_offset(), small_shear(),
              moderate_gain(), pixel_offset(), 1'b0);
    random_run(40);
    wait_idle();

    if (sb.errors == 0) begin
      $display("affine_warp_bilinear verification clean");
    end else begin
      $display("affine_warp_bilinear verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/affw_pkg.sv
rtl/core/affw_if.sv
rtl/core/affw_ram.sv
rtl/core/affw_geom.sv
rtl/core/affw_blend.sv
rtl/core/affine_warp_bilinear.sv
rtl/core/affw_chk.sv
tb/tb.sv
